// ----- rtl/hst_pkg.sv -----
// Shared constants, transaction types and a helper function of the handle slot table.
package hst_pkg;

  localparam int CAPACITY     = 1024;
  localparam int INITIAL_SIZE = 1;
  localparam int GROW_FACTOR  = 2;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int SIZE_W = IDX_W + 1;
  localparam int VAL_W  = 64;

  // The occupancy map holds one bit per slot, one row of ROW_W bits per RAM word.
  localparam int ROW_W  = 64;
  localparam int ROW_SH = $clog2(ROW_W);
  localparam int ROWS   = CAPACITY / ROW_W;
  localparam int ROW_AW = $clog2(ROWS);

  localparam int INIT_SIZE = (INITIAL_SIZE > CAPACITY) ? CAPACITY : INITIAL_SIZE;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SET = 2'd1;
  localparam logic [1:0] MODE_GET = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] slot_index;
    logic [VAL_W-1:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic [VAL_W-1:0] read_value;
    logic [1:0]       status;
  } result_t;

  // Returns {found, index} of the lowest set bit of a row.
  function automatic logic [ROW_SH:0] first_one(input logic [ROW_W-1:0] v);
    logic [ROW_SH:0] r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, ROW_SH'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/hst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/handle_slot_table_top.sv -----
// Top level of the handle slot table: sequencer, occupancy map and slot store.
//
//  channel   handshake               payload
//  --------  ----------------------  ----------------------------------
//  command   start, busy             item   (mode, slot_index, item_value)
//  result    done (one-cycle strobe) result (result_index, read_value, status)
//
// Get, set, failed adds and adds of zero give their result strobe from the lookup
// state. An add that fills a slot then, unless it took the last free slot, scans
// the occupancy map for the next free slot, one 64-slot row per cycle through the
// map's read port, at most 16 rows for 1024 slots.
// After reset a clearing pass writes the 16 occupancy rows, one per cycle;
// busy stays high until the pass ends. The receiver takes every result.
module handle_slot_table_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  hst_pkg::cmd_t    item,
  output logic             busy,
  output logic             done,
  output hst_pkg::result_t result
);
  import hst_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR    = 5'b00001,
    S_IDLE     = 5'b00010,
    S_LOOK     = 5'b00100,
    S_SCAN_RD  = 5'b01000,
    S_SCAN_CHK = 5'b10000
  } state_t;

  state_t state;

  logic [ROW_AW-1:0] clr_cnt;
  logic [SIZE_W-1:0] first_free;
  logic [SIZE_W-1:0] free_count;
  logic [SIZE_W-1:0] active_size;
  logic [SIZE_W-1:0] scan_pos;
  logic [1:0]        op;
  logic [IDX_W-1:0]  tgt;
  logic [VAL_W-1:0]  val;
  logic              add_fail;

  // Opening or growing the table for an add.
  logic [SIZE_W-1:0] room_size;
  logic [SIZE_W-1:0] room_lf;
  logic [SIZE_W-1:0] room_fc;
  logic [SIZE_W-1:0] grown;
  logic [31:0]       grow_prod;
  logic              room_ok;

  always_comb begin
    grow_prod = 32'(active_size) * GROW_FACTOR;
    grown     = (grow_prod > 32'(CAPACITY)) ? SIZE_W'(CAPACITY) : SIZE_W'(grow_prod);
    room_size = active_size;
    room_lf   = first_free;
    room_fc   = free_count;
    room_ok   = 1'b1;
    if (active_size == '0) begin
      room_size = SIZE_W'(INIT_SIZE);
      room_lf   = '0;
      room_fc   = SIZE_W'(INIT_SIZE);
    end else if (free_count == '0) begin
      if (active_size >= SIZE_W'(CAPACITY)) begin
        room_ok = 1'b0;
      end else begin
        room_lf   = active_size;
        room_fc   = grown - active_size;
        room_size = grown;
      end
    end
  end

  // Memories: the occupancy map doubles as the valid bits of the slot store.
  logic              occ_we;
  logic [ROW_AW-1:0] occ_waddr;
  logic [ROW_W-1:0]  occ_wdata;
  logic [ROW_AW-1:0] occ_raddr;
  logic [ROW_W-1:0]  occ_rdata;
  logic              store_we;
  logic [VAL_W-1:0]  store_rdata;

  hst_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  hst_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (tgt),
    .wdata (val),
    .raddr (item.slot_index),
    .rdata (store_rdata)
  );

  // Scan of one occupancy row for a free slot inside the active size.
  logic [ROW_AW-1:0] scan_row;
  logic [SIZE_W-1:0] next_row_pos;
  logic [ROW_W-1:0]  hi_mask;
  logic [ROW_W-1:0]  lo_mask;
  logic [ROW_W-1:0]  free_bits;
  logic [ROW_SH:0]   hit;

  always_comb begin
    scan_row     = scan_pos[IDX_W-1:ROW_SH];
    next_row_pos = {(ROW_AW + 1)'({1'b0, scan_row} + 1'b1), {ROW_SH{1'b0}}};
    hi_mask      = {ROW_W{1'b1}} << scan_pos[ROW_SH-1:0];
    if (active_size[SIZE_W-1:ROW_SH] > {1'b0, scan_row}) begin
      lo_mask = {ROW_W{1'b1}};
    end else begin
      lo_mask = ~({ROW_W{1'b1}} << active_size[ROW_SH-1:0]);
    end
    free_bits = ~occ_rdata & hi_mask & lo_mask;
    hit       = first_one(free_bits);
  end

  always_comb begin
    case (state)
      S_IDLE: begin
        occ_raddr = (item.mode == MODE_ADD) ? room_lf[IDX_W-1:ROW_SH]
                                            : item.slot_index[IDX_W-1:ROW_SH];
      end
      S_SCAN_CHK: occ_raddr = next_row_pos[IDX_W-1:ROW_SH];
      default:    occ_raddr = scan_row;
    endcase
  end

  // Decision of the lookup cycle, once the slot's row and contents are read.
  logic    val_nz;
  logic    occ_bit;
  logic    in_range;
  logic    do_write;
  result_t res_next;

  always_comb begin
    val_nz   = (val != '0);
    occ_bit  = occ_rdata[tgt[ROW_SH-1:0]];
    in_range = ({1'b0, tgt} < active_size);
    do_write = 1'b0;
    res_next = '{result_index: tgt, read_value: '0, status: ST_OK};
    case (op)
      MODE_ADD: begin
        if (add_fail) begin
          res_next.result_index = '0;
          res_next.status       = ST_FULL;
        end else begin
          do_write = val_nz;
        end
      end
      MODE_SET: begin
        if (!in_range) begin
          res_next.status = ST_RANGE;
        end else if (!occ_bit) begin
          res_next.status = ST_EMPTY;
        end else begin
          do_write = 1'b1;
        end
      end
      MODE_GET: begin
        if (!in_range) begin
          res_next.status = ST_RANGE;
        end else begin
          res_next.read_value = occ_bit ? store_rdata : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    store_we  = 1'b0;
    occ_we    = 1'b0;
    occ_waddr = tgt[IDX_W-1:ROW_SH];
    occ_wdata = occ_rdata;
    case (state)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_cnt;
        occ_wdata = '0;
      end
      S_LOOK: begin
        store_we                    = do_write;
        occ_we                      = do_write;
        occ_wdata[tgt[ROW_SH-1:0]]  = val_nz;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_cnt     <= '0;
      first_free  <= '0;
      free_count  <= '0;
      active_size <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ROW_AW'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op    <= item.mode;
            val   <= item.item_value;
            state <= S_LOOK;
            if (item.mode == MODE_ADD) begin
              tgt         <= room_lf[IDX_W-1:0];
              add_fail    <= !room_ok || (room_lf >= room_size);
              first_free  <= room_lf;
              free_count  <= room_fc;
              active_size <= room_size;
            end else begin
              tgt      <= item.slot_index;
              add_fail <= 1'b0;
            end
          end
        end
        S_LOOK: begin
          result <= res_next;
          if (op == MODE_ADD && do_write) begin
            free_count <= free_count - 1'b1;
            if (free_count == SIZE_W'(1)) begin
              first_free <= active_size;
              done       <= 1'b1;
              state      <= S_IDLE;
            end else begin
              scan_pos <= {1'b0, tgt} + 1'b1;
              state    <= S_SCAN_RD;
            end
          end else begin
            // A set that writes zero frees its slot.
            if (op == MODE_SET && do_write && !val_nz) begin
              free_count <= free_count + 1'b1;
              if ({1'b0, tgt} < first_free) begin
                first_free <= {1'b0, tgt};
              end
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCAN_RD: begin
          if (scan_pos >= active_size) begin
            first_free <= active_size;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (hit[ROW_SH]) begin
            first_free <= {1'b0, scan_row, hit[ROW_SH-1:0]};
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (next_row_pos >= active_size) begin
            first_free <= active_size;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            // The next row was requested this cycle; keep scanning.
            scan_pos <= next_row_pos;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- rtl/hst_checker.sv -----
// Port-level checker of the handle slot table and its bind to the top level.
module hst_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input hst_pkg::cmd_t    item,
  input logic             busy,
  input logic             done,
  input hst_pkg::result_t result
);
  import hst_pkg::*;

  // The block comes out of reset busy with its clearing pass.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not make the block busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (result.result_index == '0 &&
                                            result.read_value == '0))
    else $error("failed add returned nonzero fields");

endmodule

bind handle_slot_table_top hst_checker u_hst_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .item   (item),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- bench/handle_slot_table_top_test.sv -----
// Self-checking testbench of the handle slot table: directed vectors, then random traffic.
`timescale 1ns / 1ps

module handle_slot_table_top_test;
  import hst_pkg::*;

  // The fourth mode code is undefined and must leave the table untouched.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] ALL_ONES = {VAL_W{1'b1}};
  localparam int DIR_ROWS = 24;

  typedef struct packed {
    logic    typed;
    cmd_t    cmd;
    result_t res;
  } vector_t;

  // Rows with typed set carry their expected result; the rest use the predictor.
  localparam vector_t DIRECTED [DIR_ROWS] = '{
    '{1'b1, '{MODE_GET,    10'd0,    64'd0},    '{10'd0,    64'd0,    ST_RANGE}},
    '{1'b1, '{MODE_SET,    10'd1023, ALL_ONES}, '{10'd1023, 64'd0,    ST_RANGE}},
    '{1'b1, '{MODE_UNUSED, 10'd1023, ALL_ONES}, '{10'd1023, 64'd0,    ST_OK}},
    '{1'b1, '{MODE_ADD,    10'd1023, 64'd0},    '{10'd0,    64'd0,    ST_OK}},
    '{1'b1, '{MODE_ADD,    10'd0,    ALL_ONES}, '{10'd0,    64'd0,    ST_OK}},
    '{1'b1, '{MODE_GET,    10'd0,    64'd0},    '{10'd0,    ALL_ONES, ST_OK}},
    '{1'b1, '{MODE_ADD,    10'd0,    64'd1},    '{10'd1,    64'd0,    ST_OK}},
    '{1'b1, '{MODE_ADD,    10'd0,    64'h8000_0000_0000_0000}, '{10'd2, 64'd0, ST_OK}},
    '{1'b1, '{MODE_SET,    10'd3,    64'd5},    '{10'd3,    64'd0,    ST_EMPTY}},
    '{1'b1, '{MODE_SET,    10'd4,    64'd5},    '{10'd4,    64'd0,    ST_RANGE}},
    '{1'b1, '{MODE_GET,    10'd3,    64'd0},    '{10'd3,    64'd0,    ST_OK}},
    '{1'b1, '{MODE_SET,    10'd1,    64'd0},    '{10'd1,    64'd0,    ST_OK}},
    '{1'b1, '{MODE_ADD,    10'd0,    64'd0},    '{10'd1,    64'd0,    ST_OK}},
    '{1'b1, '{MODE_ADD,    10'd0,    64'h0123_4567_89ab_cdef}, '{10'd1, 64'd0, ST_OK}},
    '{1'b1, '{MODE_ADD,    10'd0,    ALL_ONES}, '{10'd3,    64'd0,    ST_OK}},
    '{1'b0, '{MODE_ADD,    10'd1023, 64'd42},   '0},
    '{1'b0, '{MODE_SET,    10'd0,    64'h5555_5555_5555_5555}, '0},
    '{1'b0, '{MODE_GET,    10'd0,    64'd0},    '0},
    '{1'b0, '{MODE_SET,    10'd2,    64'd0},    '0},
    '{1'b0, '{MODE_SET,    10'd0,    64'd0},    '0},
    '{1'b0, '{MODE_ADD,    10'd0,    64'd7},    '0},
    '{1'b0, '{MODE_GET,    10'd2,    64'd0},    '0},
    '{1'b0, '{MODE_GET,    10'd1023, ALL_ONES}, '0},
    '{1'b0, '{MODE_UNUSED, 10'd0,    64'd0},    '0}
  };

  logic    clk;
  logic    rst;
  logic    start;
  cmd_t    item;
  logic    busy;
  logic    done;
  result_t result;

  // Shadow copy of the table, kept in step with every accepted transaction.
  logic [VAL_W-1:0] shadow_slots [CAPACITY];
  int               next_free;
  int               free_slots;
  int               open_size;

  result_t pending_results [$];
  result_t due_result;
  int      mismatches;

  handle_slot_table_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the shadow table and returns the result it must produce.
  function automatic result_t table_outcome(input cmd_t c);
    result_t r;
    logic    room;
    logic    found;
    int      grown;
    int      idx;
    r.result_index = c.slot_index;
    r.read_value   = '0;
    r.status       = ST_OK;
    idx            = int'(c.slot_index);
    case (c.mode)
      MODE_ADD: begin
        room = 1'b1;
        if (open_size == 0) begin
          open_size  = INIT_SIZE;
          next_free  = 0;
          free_slots = open_size;
        end else if (free_slots == 0) begin
          if (open_size >= CAPACITY) begin
            room = 1'b0;
          end else begin
            grown      = open_size * GROW_FACTOR;
            if (grown > CAPACITY) grown = CAPACITY;
            next_free  = open_size;
            free_slots = grown - open_size;
            open_size  = grown;
          end
        end
        if (!room || next_free >= open_size) begin
          r.result_index = '0;
          r.status       = ST_FULL;
        end else begin
          r.result_index = IDX_W'(next_free);
          if (c.item_value != '0) begin
            shadow_slots[next_free] = c.item_value;
            free_slots--;
            found = 1'b0;
            if (free_slots != 0) begin
              for (int i = next_free + 1; i < open_size; i++) begin
                if (!found && shadow_slots[i] == '0) begin
                  next_free = i;
                  found     = 1'b1;
                end
              end
            end
            if (!found) next_free = open_size;
          end
        end
      end
      MODE_SET: begin
        if (idx >= open_size) begin
          r.status = ST_RANGE;
        end else if (shadow_slots[idx] == '0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_slots[idx] = c.item_value;
          if (c.item_value == '0) begin
            if (idx < next_free) next_free = idx;
            free_slots++;
          end
        end
      end
      MODE_GET: begin
        if (idx >= open_size) r.status = ST_RANGE;
        else r.read_value = shadow_slots[idx];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] random_value(input int zero_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < zero_pct) return '0;
    pick = $urandom_range(0, 9);
    if (pick == 0) return ALL_ONES;
    if (pick == 1) return VAL_W'($urandom_range(1, 255));
    return {$urandom, $urandom} | VAL_W'(pick == 2);
  endfunction

  function automatic cmd_t random_cmd(input int add_pct);
    cmd_t c;
    int   pick;
    if (open_size > 0 && $urandom_range(0, 99) < 85) begin
      c.slot_index = IDX_W'($urandom_range(0, open_size - 1));
    end else begin
      c.slot_index = IDX_W'($urandom_range(0, CAPACITY - 1));
    end
    if ($urandom_range(0, 99) < add_pct) begin
      c.mode       = MODE_ADD;
      c.item_value = random_value(5);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        c.mode       = MODE_SET;
        c.item_value = random_value(35);
      end else if (pick < 85) begin
        c.mode       = MODE_GET;
        c.item_value = random_value(50);
      end else begin
        c.mode       = MODE_UNUSED;
        c.item_value = random_value(20);
      end
    end
    return c;
  endfunction

  // Offers one command and holds it until the block accepts the transaction.
  task automatic issue(input cmd_t c, input logic typed, input result_t typed_res);
    result_t predicted;
    start <= 1'b1;
    item  <= c;
    do @(posedge clk); while (busy);
    predicted = table_outcome(c);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic maybe_idle(input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int add_pct);
    for (int k = 0; k < count; k++) begin
      issue(random_cmd(add_pct), 1'b0, '0);
      maybe_idle(idle_pct);
    end
    start <= 1'b0;
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        mismatches++;
      end else begin
        due_result = pending_results.pop_front();
        if (result.result_index !== due_result.result_index) begin
          $display("%0t: result_index expected %0d actual %0d", $time,
                   due_result.result_index, result.result_index);
          mismatches++;
        end
        if (result.read_value !== due_result.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time,
                   due_result.read_value, result.read_value);
          mismatches++;
        end
        if (result.status !== due_result.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   due_result.status, result.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    mismatches = 0;
    next_free  = 0;
    free_slots = 0;
    open_size  = 0;
    for (int i = 0; i < CAPACITY; i++) shadow_slots[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_ROWS; k++) begin
      issue(DIRECTED[k].cmd, DIRECTED[k].typed, DIRECTED[k].res);
      maybe_idle(30);
    end
    start <= 1'b0;
    drain();

    run_phase(200, 0, 40);
    run_phase(200, 57, 40);
    run_phase(150, 0, 45);
    run_phase(150, 38, 40);
    run_phase(100, 57, 60);

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
